// File: rtl/bmp_pkg.sv
`timescale 1ns / 1ps

package bmp_pkg;

    // Width of the n and r query fields (two's complement).
    localparam int FW = 13;
    // Width of a stored coefficient and of the result.
    localparam int VW = 30;
    // Modulus of all arithmetic.
    localparam logic [VW-1:0] PRIME = 30'd1000000007;
    // Largest row the triangle holds unless the top level is told otherwise.
    localparam int DEF_MAX_N = 256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_ROW,
        S_BRD,
        S_BWR,
        S_ADDR,
        S_LOOK
    } t_state;

    // Query classification handed from the decoder to the controller.
    typedef struct packed {
        logic          direct;      // answered without the triangle store
        logic [VW-1:0] direct_val;  // the answer in that case
        logic [FW-1:0] k_fold;      // column folded into the left half of the row
    } t_dec;

    function automatic logic [VW-1:0] add_mod(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PRIME}) begin
            s = s - {1'b0, PRIME};
        end
        return s[VW-1:0];
    endfunction

endpackage

// File: rtl/bmp_decode.sv
`timescale 1ns / 1ps

module bmp_decode #(
    parameter int MAX_N = bmp_pkg::DEF_MAX_N
) (
    input  logic [bmp_pkg::FW-1:0] i_n,
    input  logic [bmp_pkg::FW-1:0] i_r,
    output bmp_pkg::t_dec          o_dec
);
    import bmp_pkg::*;

    logic          w_oor;
    logic          w_is_n;
    logic          w_is_one;
    logic [FW:0]   w_n_ext;
    logic [FW:0]   w_r_plus1;

    assign w_n_ext   = {1'b0, i_n};
    assign w_r_plus1 = {1'b0, i_r} + (FW + 1)'(1);

    // Negative operands, a row beyond the triangle, or r above n give zero.
    assign w_oor = i_n[FW-1] || i_r[FW-1] || (w_n_ext > (FW + 1)'(MAX_N))
                 || ($signed(i_r) > $signed(i_n));

    // The two outer columns on each side never touch the store.
    assign w_is_n   = (i_r == FW'(1)) || (w_r_plus1 == w_n_ext);
    assign w_is_one = (i_r == '0) || (i_r == i_n);

    always_comb begin
        o_dec.direct = w_oor || w_is_n || w_is_one;
        if (w_oor) begin
            o_dec.direct_val = '0;
        end else if (w_is_n) begin
            o_dec.direct_val = {{(VW - FW){1'b0}}, i_n};
        end else begin
            o_dec.direct_val = VW'(1);
        end
        o_dec.k_fold = (i_r > (i_n >> 1)) ? (i_n - i_r) : i_r;
    end

endmodule

// File: rtl/binomial_mod_prime.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// query     in         i_in_valid / o_in_ready   i_n[12:0] signed, i_r[12:0] signed
// result    out        o_out_valid / i_out_ready o_value[29:0] unsigned
//
// Steps: a query that is out of range or lies on an outer column gives its result
// after accept and decode. A query on a row already held in the triangle passes through
// accept, decode, address and memory read. A query beyond the rows already built first
// builds each missing row m in turn: one setup step, then one read-modify-write of the
// single triangle memory per entry, for the entries of columns 2..m/2.
// Reset: only control state is cleared; the triangle memory has no clearing pass, since
// no entry is read before it is written. Stalls: a new query is taken while a finished
// result still waits in the output register; the block holds its last step until that
// register is free.

module binomial_mod_prime #(
    parameter int MAX_N = bmp_pkg::DEF_MAX_N
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [bmp_pkg::FW-1:0]  i_n,
    input  logic [bmp_pkg::FW-1:0]  i_r,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [bmp_pkg::VW-1:0]  o_value
);
    import bmp_pkg::*;

    // Row index width, triangle size (rows 4..MAX_N, columns 2..m/2) and address widths.
    localparam int RW    = $clog2(MAX_N + 1);
    localparam int DEPTH = MAX_N * MAX_N / 4 - MAX_N + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int SW    = 2 * RW;

    // The half triangle, packed row after row starting with row 4.
    logic [VW-1:0] mem [DEPTH];

    t_state        r_state, n_state;
    logic [FW-1:0] r_n_raw, r_r_raw;
    logic [RW-1:0] r_n;          // row of the current query
    logic [RW-1:0] r_k;          // folded column of the current query
    logic [SW-1:0] r_sq;         // (n-1)^2, used to locate the row
    logic [RW-1:0] r_rows;       // highest row held in the store
    logic [PW-1:0] r_wr_ptr;     // first free entry, which is the base of the next row
    logic [AW-1:0] r_prev_base;  // base of the highest stored row
    logic [AW-1:0] r_cur_base;   // base of the row under construction
    logic [RW-1:0] r_m;          // row under construction
    logic [RW-1:0] r_bk;         // column under construction
    logic [VW-1:0] r_a;          // C(m-1, k-1), carried from the previous column
    logic [AW-1:0] r_rd;         // address of C(m-1, k) in the store
    logic [VW-1:0] r_q;          // registered memory read data
    logic          r_out_valid;
    logic [VW-1:0] r_out_value;

    t_dec          w_dec;
    logic [RW-1:0] w_n_u;
    logic [RW-1:0] w_nm1;
    logic          w_out_free;
    logic          c_skip;
    logic          c_row_last;
    logic          c_rd_en;
    logic          c_wr_en;
    logic          c_out_load;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_look_addr;
    logic [SW:0]   w_look_sum;
    logic [VW-1:0] w_b;
    logic [VW-1:0] w_sum;

    bmp_decode #(
        .MAX_N (MAX_N)
    ) u_decode (
        .i_n   (r_n_raw),
        .i_r   (r_r_raw),
        .o_dec (w_dec)
    );

    assign w_n_u = r_n_raw[RW-1:0];
    assign w_nm1 = w_n_u - RW'(1);

    assign w_out_free = !r_out_valid || i_out_ready;

    // Entry address of C(n, k): floor((n-1)^2/4) - n + 2 + (k - 2).
    assign w_look_sum  = {1'b0, r_sq >> 2} + (SW + 1)'(r_k) - (SW + 1)'(r_n);
    assign w_look_addr = w_look_sum[AW-1:0];

    // On an even row the middle column is twice its left neighbor of the row above,
    // C(m-1, m/2) = C(m-1, m/2-1), so that column needs no read.
    assign w_b   = c_skip ? r_a : r_q;
    assign w_sum = add_mod(r_a, w_b);

    // Control outputs of the sequencer.
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        c_skip     = !r_m[0] && (r_bk == (r_m >> 1));
        c_row_last = (r_bk == (r_m >> 1));
        c_rd_en    = ((r_state == S_BRD) && !c_skip) || (r_state == S_ADDR);
        c_wr_en    = (r_state == S_BWR);
        c_out_load = ((r_state == S_DEC) && w_dec.direct && w_out_free)
                   || ((r_state == S_LOOK) && w_out_free);
        w_rd_addr  = (r_state == S_ADDR) ? w_look_addr : r_rd;
    end

    // Next state. Reads and writes of the store never share a cycle: each entry's operand
    // is read in one state, unless it is the middle column of an even row, and the entry is
    // written in the next, so a row is always complete before the following row reads it.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (w_dec.direct) begin
                    if (w_out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (w_n_u > r_rows) begin
                    n_state = S_ROW;
                end else begin
                    n_state = S_ADDR;
                end
            end
            S_ROW: begin
                n_state = S_BRD;
            end
            S_BRD: begin
                n_state = S_BWR;
            end
            S_BWR: begin
                if (!c_row_last) begin
                    n_state = S_BRD;
                end else if (r_m == r_n) begin
                    n_state = S_ADDR;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_ADDR: begin
                n_state = S_LOOK;
            end
            S_LOOK: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows      <= RW'(3);
            r_wr_ptr    <= '0;
            r_prev_base <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c_wr_en) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
                if (c_row_last) begin
                    r_rows      <= r_m;
                    r_prev_base <= r_cur_base;
                end
            end
            if (c_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_n_raw <= i_n;
            r_r_raw <= i_r;
        end
        if ((r_state == S_DEC) && !w_dec.direct) begin
            r_n  <= w_n_u;
            r_k  <= w_dec.k_fold[RW-1:0];
            r_sq <= SW'(w_nm1) * SW'(w_nm1);
        end
        if (r_state == S_ROW) begin
            r_m        <= r_rows + RW'(1);
            r_bk       <= RW'(2);
            r_a        <= {{(VW - RW){1'b0}}, r_rows};
            r_rd       <= r_prev_base;
            r_cur_base <= r_wr_ptr[AW-1:0];
        end
        if (c_wr_en) begin
            r_a  <= w_b;
            r_rd <= r_rd + AW'(1);
            r_bk <= r_bk + RW'(1);
        end
        if (c_out_load) begin
            r_out_value <= (r_state == S_LOOK) ? r_q : w_dec.direct_val;
        end
    end

    // Triangle memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (c_wr_en) begin
            mem[r_wr_ptr[AW-1:0]] <= w_sum;
        end
        if (c_rd_en) begin
            r_q <= mem[w_rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;

endmodule

// File: rtl/bmp_checker.sv
`timescale 1ns / 1ps

module bmp_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [bmp_pkg::VW-1:0] o_value
);
    import bmp_pkg::*;

    // A held result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_value)))
        else $error("result changed or dropped while stalled");

    // Every result is a residue.
    a_residue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_value < PRIME))
        else $error("result not reduced modulo the prime");

    // Only one query is worked on at a time.
    a_one_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second query taken while one is in progress");

    // No result comes out of reset.
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind binomial_mod_prime bmp_checker u_bmp_checker (.*);

// File: tb/sv/binomial_mod_prime_tb.sv
`timescale 1ns / 1ps

module binomial_mod_prime_tb;
    import bmp_pkg::*;

    localparam int MAX_N         = DEF_MAX_N;
    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_QUERIES = 1326;
    localparam int PHASE_LEN     = RANDOM_QUERIES / 3;
    localparam int SETTLE_CYCLES = 12;

    // One row of the directed table. Where known is set, value is the answer
    // as it can be read straight off the definition; otherwise the predictor
    // supplies it.
    typedef struct packed {
        logic [FW-1:0] n;
        logic [FW-1:0] r;
        logic          known;
        logic [VW-1:0] value;
    } t_query_row;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic [FW-1:0] i_n         = '0;
    logic [FW-1:0] i_r         = '0;
    logic          i_out_ready = 1'b0;
    logic          o_in_ready;
    logic          o_out_valid;
    logic [VW-1:0] o_value;

    // Predictor state: left half of Pascal's triangle mod the prime, columns
    // 2..m/2 of every row m that has been built so far.
    logic [VW-1:0] pascal_half [0:MAX_N][0:MAX_N/2];
    int unsigned   rows_ready;

    // Expected coefficients in transfer order.
    logic [VW-1:0] binomial_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int queries_sent;
    int values_checked;
    int mismatch_count;

    t_query_row directed_rows [DIRECTED_ROWS] = '{
        '{13'd0,     13'd0,     1'b1, 30'd1},    // r = n = 0
        '{13'd1,     13'd0,     1'b1, 30'd1},
        '{13'd1,     13'd1,     1'b1, 30'd1},
        '{13'd2,     13'd1,     1'b1, 30'd2},    // r = 1 gives n
        '{13'd3,     13'd2,     1'b1, 30'd3},    // r = n-1 gives n
        '{-13'sd1,   13'd0,     1'b1, 30'd0},    // negative n
        '{-13'sd4096, -13'sd4096, 1'b1, 30'd0},  // most negative fields
        '{13'd0,     -13'sd1,   1'b1, 30'd0},    // negative r
        '{13'd5,     13'd6,     1'b1, 30'd0},    // r above n
        '{13'd257,   13'd1,     1'b1, 30'd0},    // n just past the table
        '{13'd4095,  13'd4095,  1'b1, 30'd0},    // largest fields
        '{13'd256,   -13'sd4096, 1'b1, 30'd0},
        '{13'd0,     13'd4095,  1'b1, 30'd0},
        '{13'd256,   13'd0,     1'b1, 30'd1},    // outer columns of the last row
        '{13'd256,   13'd256,   1'b1, 30'd1},
        '{13'd256,   13'd1,     1'b1, 30'd256},
        '{13'd256,   13'd255,   1'b1, 30'd256},
        '{13'd4,     13'd2,     1'b0, 30'd0},    // first build after reset
        '{13'd5,     13'd3,     1'b0, 30'd0},    // one more row, right half folded
        '{13'd6,     13'd2,     1'b0, 30'd0},
        '{13'd12,    13'd6,     1'b0, 30'd0},    // several rows built at once
        '{13'd12,    13'd9,     1'b0, 30'd0},
        '{13'd7,     13'd3,     1'b0, 30'd0},    // row already held
        '{13'd12,    13'd2,     1'b0, 30'd0}
    };

    binomial_mod_prime #(
        .MAX_N(MAX_N)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_n         (i_n),
        .i_r         (i_r),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value)
    );

    always #10 i_clk = ~i_clk;

    // C(m,k) for a row that is built, or for an outer column of any row.
    function automatic logic [VW-1:0] coeff_lookup(input int unsigned m, input int unsigned k);
        if (k == 1 || k + 1 == m) begin
            return VW'(m);
        end
        if (k == 0 || k == m) begin
            return VW'(1);
        end
        if (k > m / 2) begin
            k = m - k;
        end
        return pascal_half[m][k];
    endfunction

    function automatic void extend_row(input int unsigned m);
        logic [VW:0] sum;
        for (int unsigned k = 2; k <= m / 2; k++) begin
            sum = {1'b0, coeff_lookup(m - 1, k - 1)} + {1'b0, coeff_lookup(m - 1, k)};
            if (sum >= {1'b0, PRIME}) begin
                sum = sum - {1'b0, PRIME};
            end
            pascal_half[m][k] = sum[VW-1:0];
        end
    endfunction

    // Answer for one query; grows the triangle the same way the block does.
    function automatic logic [VW-1:0] predict_binomial(input logic signed [FW-1:0] n_s,
                                                       input logic signed [FW-1:0] r_s);
        int n_i;
        int r_i;
        n_i = n_s;
        r_i = r_s;
        if (n_i > MAX_N || n_i < 0 || r_i < 0 || r_i > n_i) begin
            return '0;
        end
        if (!(r_i <= 1 || r_i + 1 >= n_i)) begin
            while (rows_ready < n_i) begin
                rows_ready++;
                extend_row(rows_ready);
            end
        end
        return coeff_lookup(n_i, r_i);
    endfunction

    // Presents one query, idling first at the current rate, and records the
    // expected coefficient once the transfer has happened.
    task automatic send_query(input logic [FW-1:0] qn, input logic [FW-1:0] qr,
                              input logic known, input logic [VW-1:0] typed);
        logic [VW-1:0] predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_n        <= qn;
        i_r        <= qr;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_binomial(qn, qr);
        binomial_q.push_back(known ? typed : predicted);
        queries_sent++;
    endtask

    // Holds the query channel idle until every outstanding result is back.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (binomial_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random query. Most are well formed with n under a ceiling that rises
    // through the run, so the triangle grows a few rows at a time; the rest
    // are raw 13-bit noise and queries right at the range limits.
    task automatic random_query(input int idx);
        int            ceil_n;
        int unsigned   sel;
        logic [FW-1:0] qn;
        logic [FW-1:0] qr;
        ceil_n = 12 + (idx * (MAX_N - 12)) / 600;
        if (ceil_n > MAX_N) begin
            ceil_n = MAX_N;
        end
        sel = $urandom_range(99);
        if (sel < 70) begin
            qn = FW'($urandom_range(ceil_n));
            case ($urandom_range(9))
                0:       qr = '0;
                1:       qr = FW'(1);
                2:       qr = qn;
                3:       qr = qn - FW'(1);
                default: qr = FW'($urandom_range(qn));
            endcase
        end else if (sel < 85) begin
            qn = FW'($urandom);
            qr = FW'($urandom);
        end else begin
            case ($urandom_range(4))
                0:       qn = FW'(MAX_N);
                1:       qn = FW'(MAX_N + 1);
                2:       qn = '1;
                3:       qn = '0;
                default: qn = FW'($urandom_range(MAX_N));
            endcase
            case ($urandom_range(3))
                0:       qr = '1;
                1:       qr = qn + FW'(1);
                2:       qr = qn;
                default: qr = {1'b1, {(FW-1){1'b0}}};
            endcase
        end
        send_query(qn, qr, 1'b0, '0);
    endtask

    // Result side: random back-pressure and the comparison of every transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (binomial_q.size() == 0) begin
                    $error("unexpected result transfer: value %0d", o_value);
                    mismatch_count++;
                end else begin
                    if (o_value !== binomial_q[0]) begin
                        $error("value mismatch: expected %0d, actual %0d",
                               binomial_q[0], o_value);
                        mismatch_count++;
                    end
                    void'(binomial_q.pop_front());
                    values_checked++;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        rows_ready     = 3;
        queries_sent   = 0;
        values_checked = 0;
        mismatch_count = 0;
        send_idle_pct  = 33;
        recv_idle_pct  = 69;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_query(directed_rows[i].n, directed_rows[i].r,
                       directed_rows[i].known, directed_rows[i].value);
        end
        wait_results_drained();

        for (int i = 0; i < RANDOM_QUERIES; i++) begin
            if (i == PHASE_LEN) begin
                wait_results_drained();
                send_idle_pct = 69;
                recv_idle_pct = 33;
            end else if (i == 2 * PHASE_LEN) begin
                wait_results_drained();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_query(i);
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d queries (%0d from the directed table), compared %0d results.",
                 queries_sent, DIRECTED_ROWS, values_checked);
        $display("Triangle grown on demand up to row %0d; %0d mismatches.",
                 rows_ready, mismatch_count);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/bmp_pkg.sv
rtl/bmp_decode.sv
rtl/binomial_mod_prime.sv
rtl/bmp_checker.sv
tb/sv/binomial_mod_prime_tb.sv
